[hdl/srd_pkg.sv]
package srd_pkg;

	localparam logic [2:0] OP_FILL = 3'd0;
	localparam logic [2:0] OP_RECT = 3'd1;
	localparam logic [2:0] OP_DISC = 3'd2;
	localparam logic [2:0] OP_LINE = 3'd3;
	localparam logic [2:0] OP_READ = 3'd4;

	localparam int QUEUE_DEPTH = 2;

	// One classified command. Scan bounds are already clipped to the canvas.
	typedef struct packed {
		logic [2:0]         op;
		logic               empty;
		logic               vert;
		logic               in_area;
		logic [31:0]        color;
		logic signed [16:0] x0;
		logic signed [16:0] x1;
		logic signed [16:0] y0;
		logic signed [16:0] y1;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic [15:0]        sw;
		logic [15:0]        sh;
		logic [31:0]        lim;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[hdl/srd_front.sv]
module srd_front #(
	parameter int EWW = 9,
	parameter int EHW = 9
) (
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic [2:0]         operation,
	input  logic [31:0]        color,
	input  logic signed [15:0] x_a,
	input  logic signed [15:0] y_a,
	input  logic signed [15:0] x_b,
	input  logic signed [15:0] y_b,
	input  logic [15:0]        size_w,
	input  logic [15:0]        size_h,
	input  logic signed [15:0] radius,
	input  logic [EWW-1:0]     eff_w,
	input  logic [EHW-1:0]     eff_h,
	input  logic               q_full,
	output logic               push,
	output srd_pkg::cmd_t      entry
);

	logic signed [16:0] w_m1, h_m1;
	logic signed [15:0] dxl, dxh, dyl, dyh;
	logic signed [16:0] cxlo, cxhi, cylo, cyhi;
	logic               swap;
	logic signed [15:0] lax, lay, lbx, lby, ldx, ldy, ymin, ymax;
	logic signed [16:0] vlo, vhi, nxlo, nxraw, nxhi;
	logic signed [31:0] rsq;

	assign cmd_ready = !q_full;
	assign push = cmd_valid && !q_full;

	assign w_m1 = signed'(17'(eff_w)) - 17'sd1;
	assign h_m1 = signed'(17'(eff_h)) - 17'sd1;

	// Disc bounding box wraps to 16 bits before clipping.
	assign dxl = x_a - radius;
	assign dxh = x_a + radius;
	assign dyl = y_a - radius;
	assign dyh = y_a + radius;
	assign cxlo = (dxl < 16'sd0) ? 17'sd0 : 17'(dxl);
	assign cxhi = (17'(dxh) > w_m1) ? w_m1 : 17'(dxh);
	assign cylo = (dyl < 16'sd0) ? 17'sd0 : 17'(dyl);
	assign cyhi = (17'(dyh) > h_m1) ? h_m1 : 17'(dyh);
	assign rsq = radius * radius;

	// Lines run left to right; width and rise wrap to 16 bits.
	assign swap = x_a > x_b;
	assign lax = swap ? x_b : x_a;
	assign lay = swap ? y_b : y_a;
	assign lbx = swap ? x_a : x_b;
	assign lby = swap ? y_a : y_b;
	assign ldx = lbx - lax;
	assign ldy = lby - lay;
	assign ymin = (lay < lby) ? lay : lby;
	assign ymax = (lay < lby) ? lby : lay;
	assign vlo = (ymin < 16'sd0) ? 17'sd0 : 17'(ymin);
	assign vhi = (17'(ymax) > h_m1) ? h_m1 : 17'(ymax);
	assign nxlo = (lax < 16'sd0) ? 17'sd0 : 17'(lax);
	assign nxraw = 17'(lbx) - 17'sd1;
	assign nxhi = (nxraw > w_m1) ? w_m1 : nxraw;

	always_comb begin
		entry = '0;
		entry.op = operation;
		entry.color = color;
		entry.px = x_a;
		entry.py = y_a;
		entry.sw = size_w;
		entry.sh = size_h;
		entry.x0 = 17'sd0;
		entry.x1 = w_m1;
		entry.y0 = 17'sd0;
		entry.y1 = h_m1;
		unique case (operation)
			srd_pkg::OP_FILL, srd_pkg::OP_RECT: begin
				entry.empty = (w_m1 < 17'sd0) || (h_m1 < 17'sd0);
			end
			srd_pkg::OP_DISC: begin
				entry.x0 = cxlo;
				entry.x1 = cxhi;
				entry.y0 = cylo;
				entry.y1 = cyhi;
				entry.lim = 32'(rsq);
				entry.empty = (radius < 16'sd0) || (cxlo > cxhi) || (cylo > cyhi);
			end
			srd_pkg::OP_LINE: begin
				entry.px = lax;
				entry.py = lay;
				entry.dx = ldx;
				entry.dy = ldy;
				entry.vert = (ldx == 16'sd0);
				if (ldx == 16'sd0) begin
					entry.x0 = 17'(lax);
					entry.x1 = 17'(lax);
					entry.y0 = vlo;
					entry.y1 = vhi;
					entry.empty = (lax < 16'sd0) || (17'(lax) > w_m1) || (vlo > vhi);
				end else begin
					entry.x0 = nxlo;
					entry.x1 = nxhi;
					entry.empty = nxlo > nxhi;
				end
			end
			srd_pkg::OP_READ: begin
				entry.in_area = (x_a >= 16'sd0) && (17'(x_a) <= w_m1) &&
					(y_a >= 16'sd0) && (17'(y_a) <= h_m1);
			end
			default: begin
				entry.empty = 1'b1;
			end
		endcase
	end

endmodule

[hdl/srd_queue.sv]
module srd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  srd_pkg::cmd_t    wdata,
	input  logic             pop,
	output srd_pkg::cmd_t    rdata,
	output srd_pkg::q_stat_t stat
);

	srd_pkg::cmd_t slot_q [srd_pkg::QUEUE_DEPTH];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;

	assign stat.full = count_q == 2'(srd_pkg::QUEUE_DEPTH);
	assign stat.empty = count_q == 2'd0;
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[hdl/srd_div.sv]
module srd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] dividend,
	input  logic signed [15:0] divisor,
	output logic               done,
	output logic [15:0]        quot
);

	logic        run_q, done_q, neg_q;
	logic [4:0]  cnt_q;
	logic [16:0] rem_q;
	logic [31:0] acc_q;
	logic [15:0] dmag_q;
	logic [16:0] shifted, diff;
	logic        ge;

	// Restoring division on magnitudes, one quotient bit per cycle.
	assign shifted = {rem_q[15:0], acc_q[31]};
	assign ge = shifted >= {1'b0, dmag_q};
	assign diff = shifted - {1'b0, dmag_q};
	assign done = done_q;
	assign quot = neg_q ? (16'd0 - acc_q[15:0]) : acc_q[15:0];

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			dmag_q <= divisor[15] ? (16'd0 - divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[15];
			rem_q <= 17'd0;
		end else if (run_q) begin
			rem_q <= ge ? diff : shifted;
			acc_q <= {acc_q[30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 5'd0;
		end else begin
			done_q <= run_q && !start && (cnt_q == 5'd31);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 5'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					run_q <= 1'b0;
				end
			end
		end
	end

endmodule

[hdl/srd_back.sv]
module srd_back #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int EWW        = 9,
	parameter int EHW        = 9
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [EWW-1:0]  eff_w,
	input  logic [EHW-1:0]  eff_h,
	input  logic            q_valid,
	input  srd_pkg::cmd_t   q_cmd,
	output logic            pop,
	output logic            idle,
	output logic            res_valid,
	input  logic            res_ready,
	output logic [7:0]      byte_low,
	output logic [7:0]      byte_mid,
	output logic [7:0]      byte_high,
	output logic            in_canvas
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SCAN   = 4'd1;
	localparam logic [3:0] ST_LMUL   = 4'd2;
	localparam logic [3:0] ST_LSTART = 4'd3;
	localparam logic [3:0] ST_LWAIT  = 4'd4;
	localparam logic [3:0] ST_COL    = 4'd5;
	localparam logic [3:0] ST_LNEXT  = 4'd6;
	localparam logic [3:0] ST_READ   = 4'd7;
	localparam logic [3:0] ST_RDATA  = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	localparam logic [1:0] PH_C  = 2'd0;
	localparam logic [1:0] PH_P0 = 2'd1;
	localparam logic [1:0] PH_PN = 2'd2;

	logic [3:0]         state_q;
	srd_pkg::cmd_t      cmd_q;
	logic [XW-1:0]      x_q;
	logic [YW-1:0]      y_q, yend_q;
	logic [1:0]         phase_q;
	logic signed [31:0] prod_q;
	logic [15:0]        c_q;
	logic signed [15:0] yprev_q;
	logic [31:0]        rd_q;
	logic [31:0]        mem_q [DEPTH];

	logic               valid_s1, hit_s1, disc_s1;
	logic [AW-1:0]      addr_s1;
	logic [31:0]        exsq_s1, eysq_s1;

	logic               emit, cand, wr_en, out_free, res_load;
	logic [15:0]        rcx, rcy;
	logic signed [17:0] ex, ey;
	logic signed [35:0] exsq, eysq;
	logic [31:0]        sq_sum;
	logic [AW-1:0]      pix_addr, rd_addr;
	logic signed [16:0] arg;
	logic signed [32:0] prod;
	logic               div_done;
	logic [15:0]        quot;
	logic signed [15:0] ynext, ymn, ymx;
	logic signed [16:0] h_m1, clo, chi;

	srd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_LSTART),
		.dividend (prod_q),
		.divisor  (cmd_q.dx),
		.done     (div_done),
		.quot     (quot)
	);

	assign pop = (state_q == ST_IDLE) && q_valid;
	assign idle = state_q == ST_IDLE;
	assign emit = (state_q == ST_SCAN) || (state_q == ST_COL);
	assign out_free = !res_valid || res_ready;
	assign res_load = ((state_q == ST_RDATA) || (state_q == ST_DONE)) && out_free;

	// Per-pixel tests: rectangle membership with 16-bit wrap, disc distance.
	assign rcx = 16'(x_q) - cmd_q.px;
	assign rcy = 16'(y_q) - cmd_q.py;
	assign cand = (cmd_q.op != srd_pkg::OP_RECT) || ((rcx < cmd_q.sw) && (rcy < cmd_q.sh));
	assign ex = signed'(18'(x_q)) - 18'(cmd_q.px);
	assign ey = signed'(18'(y_q)) - 18'(cmd_q.py);
	assign exsq = ex * ex;
	assign eysq = ey * ey;
	assign pix_addr = AW'(y_q) * AW'(eff_w) + AW'(x_q);
	assign rd_addr = AW'(cmd_q.py) * AW'(eff_w) + AW'(cmd_q.px);
	assign sq_sum = exsq_s1 + eysq_s1;
	assign wr_en = valid_s1 && hit_s1 && (!disc_s1 || (sq_sum <= cmd_q.lim));

	// Line column math: y = (x * dy) / dx + c, all wrapped to 16 bits.
	assign arg = (phase_q == PH_C) ? 17'(cmd_q.px) :
		(phase_q == PH_PN) ? (signed'(17'(x_q)) + 17'sd1) : signed'(17'(x_q));
	assign prod = arg * cmd_q.dy;
	assign ynext = quot + c_q;
	assign ymn = (yprev_q < ynext) ? yprev_q : ynext;
	assign ymx = (yprev_q < ynext) ? ynext : yprev_q;
	assign h_m1 = signed'(17'(eff_h)) - 17'sd1;
	assign clo = (ymn < 16'sd0) ? 17'sd0 : 17'(ymn);
	assign chi = (17'(ymx) > h_m1) ? h_m1 : 17'(ymx);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr_s1] <= cmd_q.color;
		end
		if ((state_q == ST_READ) && cmd_q.in_area) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= pix_addr;
		hit_s1 <= cand;
		disc_s1 <= cmd_q.op == srd_pkg::OP_DISC;
		exsq_s1 <= exsq[31:0];
		eysq_s1 <= eysq[31:0];
		if (pop) begin
			cmd_q <= q_cmd;
		end
		if (state_q == ST_LMUL) begin
			prod_q <= prod[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_s1 <= 1'b0;
			res_valid <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			yend_q <= '0;
			phase_q <= PH_C;
			c_q <= '0;
			yprev_q <= '0;
			byte_low <= '0;
			byte_mid <= '0;
			byte_high <= '0;
			in_canvas <= 1'b0;
		end else begin
			valid_s1 <= emit;
			if (res_load) begin
				res_valid <= 1'b1;
			end else if (res_valid && res_ready) begin
				res_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						x_q <= XW'(q_cmd.x0);
						y_q <= YW'(q_cmd.y0);
						yend_q <= YW'(q_cmd.y1);
						phase_q <= PH_C;
						priority if (q_cmd.empty) begin
							state_q <= ST_DONE;
						end else if (q_cmd.op == srd_pkg::OP_LINE) begin
							state_q <= q_cmd.vert ? ST_COL : ST_LMUL;
						end else if (q_cmd.op == srd_pkg::OP_READ) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (x_q == XW'(cmd_q.x1)) begin
						x_q <= XW'(cmd_q.x0);
						if (y_q == YW'(cmd_q.y1)) begin
							state_q <= ST_DONE;
						end else begin
							y_q <= y_q + YW'(1);
						end
					end else begin
						x_q <= x_q + XW'(1);
					end
				end
				ST_LMUL: begin
					state_q <= ST_LSTART;
				end
				ST_LSTART: begin
					state_q <= ST_LWAIT;
				end
				ST_LWAIT: begin
					if (div_done) begin
						if (phase_q == PH_C) begin
							c_q <= cmd_q.py - quot;
							phase_q <= PH_P0;
							state_q <= ST_LMUL;
						end else if (phase_q == PH_P0) begin
							yprev_q <= ynext;
							phase_q <= PH_PN;
							state_q <= ST_LMUL;
						end else begin
							yprev_q <= ynext;
							if (clo <= chi) begin
								y_q <= YW'(clo);
								yend_q <= YW'(chi);
								state_q <= ST_COL;
							end else begin
								state_q <= ST_LNEXT;
							end
						end
					end
				end
				ST_COL: begin
					if (y_q == yend_q) begin
						state_q <= cmd_q.vert ? ST_DONE : ST_LNEXT;
					end else begin
						y_q <= y_q + YW'(1);
					end
				end
				ST_LNEXT: begin
					if (x_q == XW'(cmd_q.x1)) begin
						state_q <= ST_DONE;
					end else begin
						x_q <= x_q + XW'(1);
						state_q <= ST_LMUL;
					end
				end
				ST_READ: begin
					state_q <= ST_RDATA;
				end
				ST_RDATA: begin
					if (out_free) begin
						in_canvas <= cmd_q.in_area;
						byte_low <= cmd_q.in_area ? rd_q[7:0] : 8'd0;
						byte_mid <= cmd_q.in_area ? rd_q[15:8] : 8'd0;
						byte_high <= cmd_q.in_area ? rd_q[23:16] : 8'd0;
						state_q <= ST_IDLE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						in_canvas <= 1'b0;
						byte_low <= 8'd0;
						byte_mid <= 8'd0;
						byte_high <= 8'd0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/shape_raster_draw_engine.sv]
// Raster draw engine over a 32-bit word-per-pixel frame store.
// Commands arrive on the cmd channel (valid/ready); each command gives one
// result word on the res channel (valid/ready). Only a pixel read returns
// data; every other command answers with all result fields zero.
// The canvas size is set through the cfg write port (index 0 width,
// index 1 height); both reset to 256. The user writes it only while
// the engine is idle; the block itself does not enforce this. A
// two-entry command queue sits between the decoder and the draw
// sequencer, so the sender can run ahead of a busy sequencer. One pixel
// is written per cycle while scanning. Per command: fill and rectangle
// scan the whole canvas; disc, its clipped bounding box; sloped line, a
// multiply and a divide for the intercept and the first column, then
// per column a multiply, a divide and one pixel per covered row;
// vertical line, one pixel per row; pixel read, one frame store read.
// Reset clears the control state and the queue; frame store contents are
// undefined until a fill or draw writes them. When the receiver stalls,
// the result register holds, the sequencer waits, and commands keep
// filling the queue until it is full.
module shape_raster_draw_engine #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [8:0]         cfg_data,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic [2:0]         operation,
	input  logic [31:0]        color,
	input  logic signed [15:0] x_a,
	input  logic signed [15:0] y_a,
	input  logic signed [15:0] x_b,
	input  logic signed [15:0] y_b,
	input  logic [15:0]        size_w,
	input  logic [15:0]        size_h,
	input  logic signed [15:0] radius,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [7:0]         byte_low,
	output logic [7:0]         byte_mid,
	output logic [7:0]         byte_high,
	output logic               in_canvas
);

	localparam int EWW = $clog2(MAX_WIDTH + 1);
	localparam int EHW = $clog2(MAX_HEIGHT + 1);
	localparam logic REG_WIDTH = 1'b0;

	logic [8:0]       canvas_width_q, canvas_height_q;
	logic [EWW-1:0]   eff_w;
	logic [EHW-1:0]   eff_h;
	logic             push, pop, bk_idle;
	srd_pkg::cmd_t    entry, head;
	srd_pkg::q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q <= 9'd256;
			canvas_height_q <= 9'd256;
		end else if (cfg_write) begin
			if (cfg_index == REG_WIDTH) begin
				canvas_width_q <= cfg_data;
			end else begin
				canvas_height_q <= cfg_data;
			end
		end
	end

	assign eff_w = (32'(canvas_width_q) > MAX_WIDTH) ? EWW'(MAX_WIDTH) : EWW'(canvas_width_q);
	assign eff_h = (32'(canvas_height_q) > MAX_HEIGHT) ? EHW'(MAX_HEIGHT) : EHW'(canvas_height_q);

	srd_front #(
		.EWW (EWW),
		.EHW (EHW)
	) u_front (
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.operation (operation),
		.color     (color),
		.x_a       (x_a),
		.y_a       (y_a),
		.x_b       (x_b),
		.y_b       (y_b),
		.size_w    (size_w),
		.size_h    (size_h),
		.radius    (radius),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.q_full    (q_stat.full),
		.push      (push),
		.entry     (entry)
	);

	srd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.pop    (pop),
		.rdata  (head),
		.stat   (q_stat)
	);

	srd_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.EWW        (EWW),
		.EHW        (EHW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.q_valid   (!q_stat.empty),
		.q_cmd     (head),
		.pop       (pop),
		.idle      (bk_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.byte_low  (byte_low),
		.byte_mid  (byte_mid),
		.byte_high (byte_high),
		.in_canvas (in_canvas)
	);

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty at once");

	a_idle_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(bk_idle && !q_stat.empty && !(cmd_valid && cmd_ready)) |=> !q_stat.full)
		else $error("idle sequencer did not take a queued word");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !in_canvas) |-> (byte_low == 8'd0 && byte_mid == 8'd0 &&
		byte_high == 8'd0))
		else $error("result bytes set without an in-canvas read");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

	localparam int LIMIT_CYCLES = 10000000;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] col;
		shortint     xa, ya, xb, yb;
		logic [15:0] sw, sh;
		shortint     rad;
	} draw_cmd_t;

	typedef struct {
		logic [7:0] lo, mid, hi;
		logic       in_area;
	} pixel_word_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_write = 0;
	logic cfg_index = 0;
	logic [8:0] cfg_data = '0;
	logic cmd_valid = 0;
	logic cmd_ready;
	logic [2:0] operation = '0;
	logic [31:0] color = '0;
	logic signed [15:0] x_a = '0, y_a = '0, x_b = '0, y_b = '0;
	logic [15:0] size_w = '0, size_h = '0;
	logic signed [15:0] radius = '0;
	logic res_valid;
	logic res_ready = 0;
	logic [7:0] byte_low, byte_mid, byte_high;
	logic in_canvas;

	shape_raster_draw_engine dut (.*);

	always #5 clk = ~clk;

	// Predictor state: the frame and the canvas size as last written.
	logic [31:0] frame_words [65536];
	int unsigned canvas_w = 256, canvas_h = 256;
	pixel_word_t expected_px [$];
	int mismatches = 0;
	int cycles = 0;
	bit calm = 0;
	bit hold_request = 0;

	function automatic int wrap16(int v);
		return int'(shortint'(v));
	endfunction

	function automatic int cur_w();
		return canvas_w > 256 ? 256 : canvas_w;
	endfunction

	function automatic int cur_h();
		return canvas_h > 256 ? 256 : canvas_h;
	endfunction

	function automatic void plot(int x, int y, logic [31:0] c);
		if (x < 0 || x >= cur_w() || y < 0 || y >= cur_h())
			return;
		frame_words[y * cur_w() + x] = c;
	endfunction

	function automatic void scan_line(draw_cmd_t d);
		int ax, ay, bx, by, t, dx, dy, icpt, lo, hi, y0, y1;
		ax = d.xa; ay = d.ya; bx = d.xb; by = d.yb;
		if (ax > bx) begin
			t = ax; ax = bx; bx = t;
			t = ay; ay = by; by = t;
		end
		dx = wrap16(bx - ax);
		dy = wrap16(by - ay);
		if (dx == 0) begin
			lo = (ay < by ? ay : by); if (lo < 0) lo = 0;
			hi = (ay > by ? ay : by); if (hi > cur_h() - 1) hi = cur_h() - 1;
			for (int y = lo; y <= hi; y++)
				plot(ax, y, d.col);
			return;
		end
		icpt = wrap16(ay - (ax * dy) / dx);
		lo = ax < 0 ? 0 : ax;
		hi = (bx - 1 < cur_w() - 1) ? bx - 1 : cur_w() - 1;
		for (int x = lo; x <= hi; x++) begin
			y0 = wrap16((x * dy) / dx + icpt);
			y1 = wrap16(((x + 1) * dy) / dx + icpt);
			if (y0 > y1) begin
				t = y0; y0 = y1; y1 = t;
			end
			if (y0 < 0) y0 = 0;
			if (y1 > cur_h() - 1) y1 = cur_h() - 1;
			for (int y = y0; y <= y1; y++)
				plot(x, y, d.col);
		end
	endfunction

	function automatic pixel_word_t rasterize(draw_cmd_t d);
		pixel_word_t r;
		int x0, x1, y0, y1;
		int unsigned ex, ey, lim;
		logic [31:0] p;
		r = '{default: '0};
		case (d.op)
			srd_pkg::OP_FILL: begin
				for (int i = 0; i < cur_w() * cur_h(); i++)
					frame_words[i] = d.col;
			end
			srd_pkg::OP_RECT: begin
				for (int y = 0; y < cur_h(); y++)
					if (((y - int'(d.ya)) & 16'hFFFF) < d.sh)
						for (int x = 0; x < cur_w(); x++)
							if (((x - int'(d.xa)) & 16'hFFFF) < d.sw)
								plot(x, y, d.col);
			end
			srd_pkg::OP_DISC: begin
				if (d.rad >= 0) begin
					x0 = wrap16(d.xa - d.rad); x1 = wrap16(d.xa + d.rad);
					y0 = wrap16(d.ya - d.rad); y1 = wrap16(d.ya + d.rad);
					if (x0 < 0) x0 = 0;
					if (y0 < 0) y0 = 0;
					if (x1 > cur_w() - 1) x1 = cur_w() - 1;
					if (y1 > cur_h() - 1) y1 = cur_h() - 1;
					lim = int'(d.rad) * int'(d.rad);
					for (int y = y0; y <= y1; y++)
						for (int x = x0; x <= x1; x++) begin
							ex = x - d.xa;
							ey = y - d.ya;
							if (ex * ex + ey * ey <= lim)
								plot(x, y, d.col);
						end
				end
			end
			srd_pkg::OP_LINE: scan_line(d);
			srd_pkg::OP_READ: begin
				if (d.xa >= 0 && d.xa < cur_w() && d.ya >= 0 && d.ya < cur_h()) begin
					p = frame_words[d.ya * cur_w() + d.xa];
					r.lo = p[7:0];
					r.mid = p[15:8];
					r.hi = p[23:16];
					r.in_area = 1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: checks each accepted word and decides the next ready.
	int stall_left = 0;
	always @(posedge clk) begin
		pixel_word_t e;
		if (res_valid && res_ready) begin
			if (expected_px.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word at cycle %0d", cycles);
			end else begin
				e = expected_px.pop_front();
				if (e.lo !== byte_low || e.mid !== byte_mid || e.hi !== byte_high
						|| e.in_area !== in_canvas) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h %h %h %b got %h %h %h %b", e.hi, e.mid,
							e.lo, e.in_area, byte_high, byte_mid, byte_low, in_canvas);
				end
			end
		end
		if (hold_request && stall_left == 0)
			stall_left = 400;
		if (stall_left > 0) begin
			stall_left--;
			res_ready <= 0;
		end else
			res_ready <= calm || ($urandom_range(99) >= 21);
	end

	task automatic hold_off(int n);
		cmd_valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send(draw_cmd_t d);
		if (!calm && $urandom_range(99) < 21)
			hold_off($urandom_range(1, 4));
		cmd_valid <= 1;
		operation <= d.op; color <= d.col;
		x_a <= d.xa; y_a <= d.ya; x_b <= d.xb; y_b <= d.yb;
		size_w <= d.sw; size_h <= d.sh; radius <= d.rad;
		do @(posedge clk); while (!cmd_ready);
		expected_px.push_back(rasterize(d));
	endtask

	task automatic drain();
		hold_off(1);
		while (expected_px.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_canvas(int unsigned w, int unsigned h);
		drain();
		cfg_write <= 1; cfg_index <= 0; cfg_data <= w[8:0];
		@(posedge clk);
		cfg_index <= 1; cfg_data <= h[8:0];
		@(posedge clk);
		cfg_write <= 0;
		canvas_w = w & 9'h1FF;
		canvas_h = h & 9'h1FF;
	endtask

	function automatic draw_cmd_t mk(logic [2:0] op, logic [31:0] c, int xa, int ya,
			int xb = 0, int yb = 0, int sw = 0, int sh = 0, int rad = 0);
		draw_cmd_t d;
		d.op = op; d.col = c;
		d.xa = shortint'(xa); d.ya = shortint'(ya);
		d.xb = shortint'(xb); d.yb = shortint'(yb);
		d.sw = 16'(sw); d.sh = 16'(sh); d.rad = shortint'(rad);
		return d;
	endfunction

	function automatic int near(int n);
		return int'($urandom_range(0, n + 7)) - 4;
	endfunction

	function automatic draw_cmd_t random_cmd();
		draw_cmd_t d;
		int k;
		k = $urandom_range(99);
		d.col = $urandom;
		d.xa = shortint'(near(cur_w())); d.ya = shortint'(near(cur_h()));
		d.xb = shortint'(near(cur_w())); d.yb = shortint'(near(cur_h()));
		d.sw = 16'($urandom_range(0, 20)); d.sh = 16'($urandom_range(0, 20));
		d.rad = shortint'(int'($urandom_range(0, 12)) - 2);
		if ($urandom_range(9) == 0) begin
			// Full-range operands reach the wrap cases of every shape.
			d.xa = shortint'($urandom); d.ya = shortint'($urandom);
			d.xb = shortint'($urandom); d.yb = shortint'($urandom);
			d.sw = 16'($urandom); d.sh = 16'($urandom); d.rad = shortint'($urandom);
		end
		if (k < 5) d.op = srd_pkg::OP_FILL;
		else if (k < 22) d.op = srd_pkg::OP_RECT;
		else if (k < 40) d.op = srd_pkg::OP_DISC;
		else if (k < 60) d.op = srd_pkg::OP_LINE;
		else if (k < 97) d.op = srd_pkg::OP_READ;
		else d.op = 3'($urandom_range(5, 7));
		if (d.op == srd_pkg::OP_LINE && $urandom_range(4) == 0)
			d.xb = d.xa;
		return d;
	endfunction

	task automatic test_full_canvas();
		send(mk(srd_pkg::OP_FILL, 32'h12345678, 0, 0));
		send(mk(srd_pkg::OP_READ, 0, 0, 0));
		send(mk(srd_pkg::OP_READ, 0, 255, 255));
		send(mk(srd_pkg::OP_READ, 0, 256, 0));
		send(mk(srd_pkg::OP_RECT, 32'hFFFFFFFF, -3, 250, 0, 0, 10, 10));
		send(mk(srd_pkg::OP_READ, 0, 2, 255));
		send(mk(srd_pkg::OP_LINE, 32'h00A5A5A5, 200, 100, 255, 150));
		send(mk(srd_pkg::OP_READ, 0, 220, 122));
	endtask

	task automatic test_small_extremes();
		set_canvas(16, 12);
		send(mk(srd_pkg::OP_FILL, 32'hCAFEF00D, 0, 0));
		send(mk(srd_pkg::OP_RECT, 32'h00112233, 32767, -32768, 0, 0, 65535, 65535));
		send(mk(srd_pkg::OP_RECT, 32'h00445566, 14, 10, 0, 0, 65535, 3));
		send(mk(srd_pkg::OP_DISC, 32'h00778899, 8, 6, 0, 0, 0, 0, 5));
		send(mk(srd_pkg::OP_DISC, 32'h00FFFFFF, 8, 6, 0, 0, 0, 0, -1));
		send(mk(srd_pkg::OP_DISC, 32'h00ABCDEF, 32767, 32767, 0, 0, 0, 0, 32767));
		send(mk(srd_pkg::OP_LINE, 32'h00010203, 3, -5, 3, 40));
		send(mk(srd_pkg::OP_LINE, 32'h00040506, 15, 11, 0, 0));
		send(mk(srd_pkg::OP_LINE, 32'h00070809, -32768, 5, 32767, -7));
		send(mk(3'd7, 32'hFFFFFFFF, 1, 1));
		for (int y = 0; y < 12; y += 3)
			for (int x = 0; x < 16; x += 5)
				send(mk(srd_pkg::OP_READ, 0, x, y));
		send(mk(srd_pkg::OP_READ, 0, -1, 0));
		send(mk(srd_pkg::OP_READ, 0, 0, 12));
	endtask

	task automatic test_config_extremes();
		set_canvas(0, 5);
		send(mk(srd_pkg::OP_FILL, 32'h0F0F0F0F, 0, 0));
		send(mk(srd_pkg::OP_LINE, 32'h1, 0, 0, 3, 3));
		send(mk(srd_pkg::OP_READ, 0, 0, 0));
		set_canvas(511, 2);
		send(mk(srd_pkg::OP_FILL, 32'h00E0E0E0, 0, 0));
		send(mk(srd_pkg::OP_LINE, 32'h00333333, 250, 0, 262, 1));
		send(mk(srd_pkg::OP_READ, 0, 255, 1));
		send(mk(srd_pkg::OP_READ, 0, 256, 1));
		set_canvas(1, 511);
		send(mk(srd_pkg::OP_FILL, 32'h00C0C0C0, 0, 0));
		send(mk(srd_pkg::OP_DISC, 32'h00111111, 0, 255, 0, 0, 0, 0, 2));
		send(mk(srd_pkg::OP_READ, 0, 0, 254));
		send(mk(srd_pkg::OP_READ, 0, 0, 256));
	endtask

	task automatic test_backpressure();
		set_canvas(4, 4);
		send(mk(srd_pkg::OP_FILL, 32'h00ABABAB, 0, 0));
		calm = 1;
		// The receiver takes the request once and counts its own stall.
		hold_request = 1;
		wait (stall_left > 0);
		hold_request = 0;
		for (int i = 0; i < 12; i++)
			send(mk(srd_pkg::OP_READ, 0, i % 4, i / 4));
		for (int i = 0; i < 40; i++)
			send(random_cmd());
		calm = 0;
	endtask

	task automatic test_random();
		int unsigned w, h;
		for (int ph = 0; ph < 9; ph++) begin
			w = (ph == 0) ? 1 : $urandom_range(1, 24);
			h = (ph == 1) ? 1 : $urandom_range(1, 24);
			set_canvas(w, h);
			calm = (ph == 4);
			send(mk(srd_pkg::OP_FILL, $urandom, 0, 0));
			for (int i = 0; i < 80; i++)
				send(random_cmd());
		end
		calm = 0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_full_canvas();
		test_small_extremes();
		test_config_extremes();
		test_backpressure();
		test_random();
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_px.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
